// File: design/armd_pkg.sv
package armd_pkg;

    localparam int SQ_STEPS    = 32;
    localparam int DIST_STEPS  = 17;
    localparam int ANGLE_STEPS = 23;
    localparam int CW          = 40;
    localparam int ZW          = 26;

    localparam logic [16:0] DIST_MAX   = 17'h1FFFF;
    localparam logic [15:0] ANGLE_MAX  = 16'd46080;
    localparam logic [ZW-1:0] Z_90     = ZW'(90 * 65536);
    localparam logic [ZW-1:0] Z_180    = ZW'(180 * 65536);

    localparam logic REG_MIN_SCREEN = 1'b0;
    localparam logic REG_MIN_ANGLE  = 1'b1;

    localparam logic [21:0] ATAN_DEG [ANGLE_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
        22'd1
    };

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq64;

    typedef struct packed {
        logic [33:0] v;
        logic [33:0] r;
    } t_sq34;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    typedef struct packed {
        logic               pu;
        logic               nu;
        logic               tiny;
        logic signed [33:0] dot;
        logic [16:0]        sdist;
    } t_side;

    function automatic t_sq64 sq_step64(t_sq64 a, logic [63:0] b);
        t_sq64       res;
        logic [63:0] s;
        s = a.r + b;
        if (a.v >= s) begin
            res.v = a.v - s;
            res.r = (a.r >> 1) + b;
        end else begin
            res.v = a.v;
            res.r = a.r >> 1;
        end
        return res;
    endfunction

    function automatic t_sq34 sq_step34(t_sq34 a, logic [33:0] b);
        t_sq34       res;
        logic [33:0] s;
        s = a.r + b;
        if (a.v >= s) begin
            res.v = a.v - s;
            res.r = (a.r >> 1) + b;
        end else begin
            res.v = a.v;
            res.r = a.r >> 1;
        end
        return res;
    endfunction

    function automatic t_cord cordic_step(t_cord a, int i);
        t_cord                res;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] e;
        xs = a.x >>> i;
        ys = a.y >>> i;
        e  = $signed({{(ZW - 22){1'b0}}, ATAN_DEG[i]});
        if (a.y > 0) begin
            res.x = a.x + ys;
            res.y = a.y - xs;
            res.z = a.z + e;
        end else begin
            res.x = a.x - ys;
            res.y = a.y + xs;
            res.z = a.z - e;
        end
        return res;
    endfunction

endpackage

// File: design/armd_in_if.sv
interface armd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] prev_dir_x;
    logic signed [15:0] prev_dir_y;
    logic signed [15:0] prev_dir_z;
    logic signed [15:0] prev_screen_x;
    logic signed [15:0] prev_screen_y;
    logic signed [15:0] next_dir_x;
    logic signed [15:0] next_dir_y;
    logic signed [15:0] next_dir_z;
    logic signed [15:0] next_screen_x;
    logic signed [15:0] next_screen_y;

    modport source (
        output valid, prev_dir_x, prev_dir_y, prev_dir_z, prev_screen_x, prev_screen_y,
               next_dir_x, next_dir_y, next_dir_z, next_screen_x, next_screen_y,
        input  ready
    );
    modport sink (
        input  valid, prev_dir_x, prev_dir_y, prev_dir_z, prev_screen_x, prev_screen_y,
               next_dir_x, next_dir_y, next_dir_z, next_screen_x, next_screen_y,
        output ready
    );
endinterface

// File: design/armd_out_if.sv
interface armd_out_if;
    logic        valid;
    logic        ready;
    logic        moved;
    logic        prev_usable;
    logic        next_usable;
    logic [16:0] screen_distance;
    logic [15:0] angle_degrees;

    modport source (
        output valid, moved, prev_usable, next_usable, screen_distance, angle_degrees,
        input  ready
    );
    modport sink (
        input  valid, moved, prev_usable, next_usable, screen_distance, angle_degrees,
        output ready
    );
endinterface

// File: design/aim_ray_move_detector_top.sv
// Aim ray move detector.
// i_in: valid/ready channel, one transaction holds an earlier and a later aim
//   state (direction and screen position, signed Q2.14).
// o_out: valid/ready channel, one transaction per input: usable flags, screen
//   distance, angle between directions and the moved flag.
// APB port: min_screen_move at 0x0, min_angle_move at 0x4; pready tied high.
//   Write thresholds only while no transaction is in flight.
// Throughput: one transaction per cycle unless o_out.ready stalls the output; the
//   pipeline is 61 register stages: products, sums, wide multiplies, the
//   length test, 32 square-root stages, a quadrant stage, 23 CORDIC stages
//   and the output register.
// Stall: when o_out.ready is low with a result waiting, every stage holds and
//   i_in.ready drops; nothing is lost or repeated. Bubbles pass through.
// Reset: synchronous, active low; clears all stage valid bits and loads the
//   thresholds with 164 and 256.
module aim_ray_move_detector_top
    import armd_pkg::*;
#(
    parameter int COMPONENT_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    armd_in_if.sink     i_in,
    armd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ST_SQ0  = 4;
    localparam int ST_ROT  = ST_SQ0 + SQ_STEPS;
    localparam int ST_LAST = ST_ROT + ANGLE_STEPS + 1;
    localparam int NST     = ST_LAST + 1;

    localparam logic [63:0] LEN_LO = 64'd9025 << (2 * COMPONENT_FRAC_BITS);
    localparam logic [63:0] LEN_HI = 64'd11025 << (2 * COMPONENT_FRAC_BITS);
    localparam logic [63:0] TINY   = (64'd1 << (2 * COMPONENT_FRAC_BITS)) / 64'd1000000000000;
    localparam logic signed [31:0] SMIN = -(32'sd1 <<< COMPONENT_FRAC_BITS);
    localparam logic signed [31:0] SMAX = 32'sd2 <<< COMPONENT_FRAC_BITS;

    logic [16:0]    r_min_screen;
    logic [15:0]    r_min_angle;
    logic [NST-1:0] r_vld;
    logic           w_en;

    assign w_en       = !r_vld[ST_LAST] || o_out.ready;
    assign i_in.ready = w_en;
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_screen <= 17'd164;
            r_min_angle  <= 16'd256;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MIN_SCREEN: r_min_screen <= pwdata[16:0];
                REG_MIN_ANGLE:  r_min_angle  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MIN_SCREEN: prdata = {15'd0, r_min_screen};
            REG_MIN_ANGLE:  prdata = {16'd0, r_min_angle};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // stage 0: products and screen range
    logic signed [16:0] w_dx, w_dy;
    logic [31:0]        r_a_sp [3];
    logic [31:0]        r_a_sn [3];
    logic signed [31:0] r_a_dp [3];
    logic [32:0]        r_a_dx2, r_a_dy2;
    logic               r_a_psr, r_a_nsr;

    assign w_dx = 17'(i_in.next_screen_x) - 17'(i_in.prev_screen_x);
    assign w_dy = 17'(i_in.next_screen_y) - 17'(i_in.prev_screen_y);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sp[0] <= 32'(i_in.prev_dir_x * i_in.prev_dir_x);
            r_a_sp[1] <= 32'(i_in.prev_dir_y * i_in.prev_dir_y);
            r_a_sp[2] <= 32'(i_in.prev_dir_z * i_in.prev_dir_z);
            r_a_sn[0] <= 32'(i_in.next_dir_x * i_in.next_dir_x);
            r_a_sn[1] <= 32'(i_in.next_dir_y * i_in.next_dir_y);
            r_a_sn[2] <= 32'(i_in.next_dir_z * i_in.next_dir_z);
            r_a_dp[0] <= 32'(i_in.prev_dir_x * i_in.next_dir_x);
            r_a_dp[1] <= 32'(i_in.prev_dir_y * i_in.next_dir_y);
            r_a_dp[2] <= 32'(i_in.prev_dir_z * i_in.next_dir_z);
            r_a_dx2   <= 33'(w_dx * w_dx);
            r_a_dy2   <= 33'(w_dy * w_dy);
            r_a_psr   <= i_in.prev_screen_x >= SMIN && i_in.prev_screen_x <= SMAX &&
                         i_in.prev_screen_y >= SMIN && i_in.prev_screen_y <= SMAX;
            r_a_nsr   <= i_in.next_screen_x >= SMIN && i_in.next_screen_x <= SMAX &&
                         i_in.next_screen_y >= SMIN && i_in.next_screen_y <= SMAX;
        end
    end

    // stage 1: sums
    logic signed [33:0] w_dot;
    logic [31:0]        r_b_sa, r_b_sb, r_b_dmag;
    logic signed [33:0] r_b_dot;
    logic [33:0]        r_b_dsq;
    logic               r_b_psr, r_b_nsr;

    assign w_dot = 34'(r_a_dp[0]) + 34'(r_a_dp[1]) + 34'(r_a_dp[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sa   <= r_a_sp[0] + r_a_sp[1] + r_a_sp[2];
            r_b_sb   <= r_a_sn[0] + r_a_sn[1] + r_a_sn[2];
            r_b_dot  <= w_dot;
            r_b_dmag <= w_dot[33] ? 32'(-w_dot) : 32'(w_dot);
            r_b_dsq  <= 34'(r_a_dx2) + 34'(r_a_dy2);
            r_b_psr  <= r_a_psr;
            r_b_nsr  <= r_a_nsr;
        end
    end

    // stage 2: wide multiplies
    logic [45:0]        r_c_sa10, r_c_sb10;
    logic [63:0]        r_c_sasb, r_c_d2;
    logic signed [33:0] r_c_dot;
    logic [33:0]        r_c_dsq;
    logic               r_c_psr, r_c_nsr, r_c_tiny;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sa10 <= 46'(r_b_sa) * 46'd10000;
            r_c_sb10 <= 46'(r_b_sb) * 46'd10000;
            r_c_sasb <= 64'(r_b_sa) * 64'(r_b_sb);
            r_c_d2   <= 64'(r_b_dmag) * 64'(r_b_dmag);
            r_c_tiny <= 64'(r_b_sa) <= TINY || 64'(r_b_sb) <= TINY;
            r_c_dot  <= r_b_dot;
            r_c_dsq  <= r_b_dsq;
            r_c_psr  <= r_b_psr;
            r_c_nsr  <= r_b_nsr;
        end
    end

    // stage 3: length test, cross magnitude squared
    t_sq64 r_sq   [SQ_STEPS+1];
    t_sq34 r_dq   [DIST_STEPS+1];
    t_side r_side [3:ST_LAST-1];
    t_cord r_cd   [ANGLE_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0].v       <= r_c_sasb - r_c_d2;
            r_sq[0].r       <= '0;
            r_dq[0].v       <= r_c_dsq;
            r_dq[0].r       <= '0;
            r_side[3].pu    <= 64'(r_c_sa10) >= LEN_LO && 64'(r_c_sa10) <= LEN_HI && r_c_psr;
            r_side[3].nu    <= 64'(r_c_sb10) >= LEN_LO && 64'(r_c_sb10) <= LEN_HI && r_c_nsr;
            r_side[3].tiny  <= r_c_tiny;
            r_side[3].dot   <= r_c_dot;
            r_side[3].sdist <= '0;
        end
    end

    // square roots, one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[j+1] <= sq_step64(r_sq[j], 64'd1 << (62 - 2 * j));
                if (j == DIST_STEPS) begin
                    r_side[ST_SQ0+j] <= {r_side[ST_SQ0+j-1].pu, r_side[ST_SQ0+j-1].nu,
                                         r_side[ST_SQ0+j-1].tiny, r_side[ST_SQ0+j-1].dot,
                                         (r_dq[DIST_STEPS].r > 34'(DIST_MAX)) ?
                                         DIST_MAX : r_dq[DIST_STEPS].r[16:0]};
                end else begin
                    r_side[ST_SQ0+j] <= r_side[ST_SQ0+j-1];
                end
            end
        end
        if (j < DIST_STEPS) begin : g_dist
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dq[j+1] <= sq_step34(r_dq[j], 34'd1 << (32 - 2 * j));
                end
            end
        end
    end

    // quadrant: turn by -90 degrees for a negative dot product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[ST_ROT] <= r_side[ST_ROT-1];
            if (r_side[ST_ROT-1].dot < 0) begin
                r_cd[0].x <= $signed({{(CW - 32){1'b0}}, r_sq[SQ_STEPS].r[31:0]});
                r_cd[0].y <= -CW'(r_side[ST_ROT-1].dot);
                r_cd[0].z <= Z_90;
            end else begin
                r_cd[0].x <= CW'(r_side[ST_ROT-1].dot);
                r_cd[0].y <= $signed({{(CW - 32){1'b0}}, r_sq[SQ_STEPS].r[31:0]});
                r_cd[0].z <= '0;
            end
        end
    end

    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cd[i+1]          <= cordic_step(r_cd[i], i);
                r_side[ST_ROT+1+i] <= r_side[ST_ROT+i];
            end
        end
    end

    // output stage: clamp, round, threshold compare
    logic signed [ZW-1:0] w_zc;
    logic [ZW-1:0]        w_zr;
    logic [15:0]          w_q, w_ang;
    t_side                w_s;
    logic                 r_o_moved, r_o_pu, r_o_nu;
    logic [16:0]          r_o_dist;
    logic [15:0]          r_o_ang;

    assign w_s = r_side[ST_LAST-1];

    always_comb begin
        w_zc = r_cd[ANGLE_STEPS].z;
        if (w_zc < 0) begin
            w_zc = '0;
        end else if (w_zc > $signed(Z_180)) begin
            w_zc = Z_180;
        end
        w_zr  = ZW'(w_zc) + ZW'(128);
        w_q   = w_zr[23:8];
        w_ang = w_s.tiny ? '0 : ((w_q > ANGLE_MAX) ? ANGLE_MAX : w_q);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_pu    <= w_s.pu;
            r_o_nu    <= w_s.nu;
            r_o_dist  <= w_s.sdist;
            r_o_ang   <= w_ang;
            r_o_moved <= w_s.pu && w_s.nu && w_s.sdist >= r_min_screen &&
                         w_ang >= r_min_angle;
        end
    end

    assign o_out.valid           = r_vld[ST_LAST];
    assign o_out.moved           = r_o_moved;
    assign o_out.prev_usable     = r_o_pu;
    assign o_out.next_usable     = r_o_nu;
    assign o_out.screen_distance = r_o_dist;
    assign o_out.angle_degrees   = r_o_ang;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_moved_usable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.moved |-> o_out.prev_usable && o_out.next_usable)
        else $error("moved without both states usable");

    a_moved_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.moved |->
            o_out.screen_distance >= r_min_screen && o_out.angle_degrees >= r_min_angle)
        else $error("moved below thresholds");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.angle_degrees <= ANGLE_MAX)
        else $error("angle above 180 degrees");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import armd_pkg::*;

    typedef struct packed {
        logic signed [15:0] pdx, pdy, pdz, psx, psy;
        logic signed [15:0] ndx, ndy, ndz, nsx, nsy;
    } aim_pair_t;

    typedef struct packed {
        logic        moved;
        logic        pu;
        logic        nu;
        logic [16:0] sdist;
        logic [15:0] ang;
    } move_verdict_t;

    typedef struct packed {
        aim_pair_t     pair;
        logic          typed;
        move_verdict_t want;
    } stim_row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    armd_in_if  in_ch();
    armd_out_if out_ch();

    aim_ray_move_detector_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [16:0]   min_screen;
    logic [15:0]   min_angle;
    move_verdict_t verdicts_due[$];
    move_verdict_t typed_due[$];
    logic          typed_flag[$];
    int            mismatches;
    int            idle_cycles;
    bit            long_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic aim_usable(longint x, longint y, longint z, longint sx, longint sy);
        longint s;
        s = (x * x + y * y + z * z) * 10000;
        if (s < (longint'(9025) << 28) || s > (longint'(11025) << 28)) return 1'b0;
        return sx >= -16384 && sx <= 32768 && sy >= -16384 && sy <= 32768;
    endfunction

    function automatic logic [15:0] ray_angle(longint ax, longint ay, longint az,
                                              longint bx, longint by, longint bz);
        longint unsigned sa, sb, dmag, q;
        longint dot, x, y, z, nx, ny, xs, ys;
        sa = ax * ax + ay * ay + az * az;
        sb = bx * bx + by * by + bz * bz;
        if (sa == 0 || sb == 0) return 16'd0;
        dot  = ax * bx + ay * by + az * bz;
        dmag = dot < 0 ? -dot : dot;
        x = dot;
        y = int_sqrt(sa * sb - dmag * dmag);
        z = 0;
        if (x < 0) begin
            nx = y;
            y  = -x;
            x  = nx;
            z  = 90 * 65536;
        end
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                nx = x + ys;
                ny = y - xs;
                z += ATAN_DEG[i];
            end else begin
                nx = x - ys;
                ny = y + xs;
                z -= ATAN_DEG[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        q = (z + 128) >> 8;
        if (q > 46080) q = 46080;
        return q[15:0];
    endfunction

    function automatic move_verdict_t judge_move(aim_pair_t p);
        move_verdict_t   v;
        longint          dx, dy;
        longint unsigned d;
        v.pu = aim_usable(p.pdx, p.pdy, p.pdz, p.psx, p.psy);
        v.nu = aim_usable(p.ndx, p.ndy, p.ndz, p.nsx, p.nsy);
        dx = longint'(p.nsx) - longint'(p.psx);
        dy = longint'(p.nsy) - longint'(p.psy);
        d  = int_sqrt(dx * dx + dy * dy);
        v.sdist = d > 131071 ? DIST_MAX : d[16:0];
        v.ang   = ray_angle(p.pdx, p.pdy, p.pdz, p.ndx, p.ndy, p.ndz);
        v.moved = v.pu && v.nu && v.sdist >= min_screen && v.ang >= min_angle;
        return v;
    endfunction

    // scoreboard: predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        move_verdict_t want, got;
        logic          tf;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            verdicts_due.push_back(judge_move({in_ch.prev_dir_x, in_ch.prev_dir_y,
                in_ch.prev_dir_z, in_ch.prev_screen_x, in_ch.prev_screen_y,
                in_ch.next_dir_x, in_ch.next_dir_y, in_ch.next_dir_z,
                in_ch.next_screen_x, in_ch.next_screen_y}));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.moved, out_ch.prev_usable, out_ch.next_usable,
                   out_ch.screen_distance, out_ch.angle_degrees};
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %p", got);
            end else begin
                want = verdicts_due.pop_front();
                tf   = typed_flag.pop_front();
                if (tf) want = typed_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off early on
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        repeat (200) @(posedge i_clk) out_ch.ready <= ($urandom_range(0, 3) != 0);
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge i_clk);
        forever begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
            repeat (n) @(posedge i_clk);
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    task automatic send_pair(aim_pair_t p);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.prev_dir_x    <= p.pdx;
        in_ch.prev_dir_y    <= p.pdy;
        in_ch.prev_dir_z    <= p.pdz;
        in_ch.prev_screen_x <= p.psx;
        in_ch.prev_screen_y <= p.psy;
        in_ch.next_dir_x    <= p.ndx;
        in_ch.next_dir_y    <= p.ndy;
        in_ch.next_dir_z    <= p.ndz;
        in_ch.next_screen_x <= p.nsx;
        in_ch.next_screen_y <= p.nsy;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = !long_gaps ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic apb_write(logic addr_bit, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_bit, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_bit == REG_MIN_SCREEN) min_screen = data[16:0];
        else                            min_angle  = data[15:0];
    endtask

    task automatic settle;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (verdicts_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic unit_dir(real scale, output logic signed [15:0] x, y, z);
        real rr, rem;
        int  lim, xi, yi;
        rr  = 16384.0 * scale;
        lim = $rtoi(rr);
        xi  = int'($urandom_range(0, 2 * lim)) - lim;
        rem = rr * rr - real'(xi) * real'(xi);
        lim = $rtoi($sqrt(rem < 0.0 ? 0.0 : rem));
        yi  = int'($urandom_range(0, 2 * lim)) - lim;
        rem = rem - real'(yi) * real'(yi);
        x = 16'(xi);
        y = 16'(yi);
        z = 16'($rtoi($sqrt(rem < 0.0 ? 0.0 : rem)));
        if ($urandom_range(0, 1)) z = -z;
    endtask

    function automatic logic signed [15:0] screen_pos();
        return $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'(int'($urandom_range(0, 49152)) - 16384);
    endfunction

    function automatic logic signed [15:0] nudge(logic signed [15:0] v, int span);
        int r;
        r = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    task automatic random_pairs(int count);
        aim_pair_t p;
        real       sc;
        int        kind, span;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                p = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end else begin
                sc = (kind < 4) ? 0.93 + 0.14 * $urandom_range(0, 1000) / 1000.0 : 1.0;
                unit_dir(sc, p.pdx, p.pdy, p.pdz);
                p.psx = screen_pos();
                p.psy = screen_pos();
                span  = $urandom_range(0, 3) == 0 ? 12000 : 400;
                if ($urandom_range(0, 4) == 0) begin
                    unit_dir(1.0, p.ndx, p.ndy, p.ndz);
                end else begin
                    p.ndx = nudge(p.pdx, span);
                    p.ndy = nudge(p.pdy, span);
                    p.ndz = nudge(p.pdz, span);
                end
                p.nsx = nudge(p.psx, span);
                p.nsy = nudge(p.psy, span);
            end
            typed_flag.push_back(1'b0);
            send_pair(p);
        end
    endtask

    stim_row_t directed[] = '{
        '{'0, 1'b1, '0},
        '{{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
           16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
           16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
        '{{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           16'sd0, 16'sd16384, 16'sd0, 16'sd2000, 16'sd0}, 1'b0, '0},
        '{{16'sd16384, 16'sd0, 16'sd0, -16'sd16384, -16'sd16384,
           -16'sd16384, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{{16'sd15565, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           16'sd15564, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{{16'sd17203, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           16'sd0, 16'sd17204, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{{16'sd0, 16'sd16384, 16'sd0, -16'sd16385, 16'sd0,
           16'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd16385}, 1'b0, '0},
        '{{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           16'sd0, 16'sd0, 16'sd16384, 16'sd164, 16'sd0}, 1'b0, '0},
        '{{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
           16'sd0, 16'sd286, 16'sd16381, 16'sd164, 16'sd0}, 1'b0, '0},
        '{{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
           16'sd0, 16'sd200, 16'sd16383, 16'sd163, 16'sd0}, 1'b0, '0},
        '{{16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000,
           16'sh7FFF, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0}
    };

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        long_gaps     = 1'b0;
        min_screen    = 17'd164;
        min_angle     = 16'd256;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_ch.valid   <= 1'b0;
        {in_ch.prev_dir_x, in_ch.prev_dir_y, in_ch.prev_dir_z, in_ch.prev_screen_x,
         in_ch.prev_screen_y, in_ch.next_dir_x, in_ch.next_dir_y, in_ch.next_dir_z,
         in_ch.next_screen_x, in_ch.next_screen_y} <= '0;
        i_rst_n       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            typed_flag.push_back(directed[k].typed);
            if (directed[k].typed) typed_due.push_back(directed[k].want);
            send_pair(directed[k].pair);
        end
        random_pairs(250);
        long_gaps = 1'b1;
        random_pairs(100);
        settle();

        apb_write(REG_MIN_SCREEN, 32'd0);
        apb_write(REG_MIN_ANGLE, 32'd0);
        random_pairs(130);
        settle();

        apb_write(REG_MIN_SCREEN, 32'd131071);
        apb_write(REG_MIN_ANGLE, 32'd46080);
        random_pairs(100);
        settle();

        for (int ph = 0; ph < 2; ph++) begin
            apb_write(REG_MIN_SCREEN, $urandom_range(0, 2000));
            apb_write(REG_MIN_ANGLE, $urandom_range(0, 1500));
            random_pairs(150);
            settle();
        end

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
